FILE: hdl/tcs_pkg.sv
// Shared types, codes and constants of the text console engine.
package tcs_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int ROW_PORT_W = 5;
    localparam int COL_PORT_W = 7;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
    localparam logic [CELL_W-1:0]  RESET_CELL   = 16'h0720;
    localparam logic [COLOR_W-1:0] RESET_FG     = 4'd7;
    localparam logic [COLOR_W-1:0] RESET_BG     = 4'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG = 2'd0,
        CFG_BG = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } t_state;

endpackage

FILE: hdl/tcs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/tcs_addr.sv
// Maps a screen row and column to a cell address through the rotating top-row pointer.
module tcs_addr
    import tcs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic [$clog2(ROWS)-1:0]         i_top,
    input  logic [$clog2(ROWS)-1:0]         i_row,
    input  logic [$clog2(COLUMNS)-1:0]      i_col,
    output logic [$clog2(ROWS*COLUMNS)-1:0] o_addr
);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SUM_W  = ROW_W + 1;
    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] phys;

    always_comb begin
        sum  = {1'b0, i_top} + {1'b0, i_row};
        phys = (sum >= SUM_W'(ROWS)) ? sum - SUM_W'(ROWS) : sum;
    end

    assign o_addr = ADDR_W'(phys[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(i_col);
endmodule

FILE: hdl/text_console_cursor_scroll.sv
// Top level of the text console engine: command sequencer, cursor and screen RAM.
//
// Commands enter on start while busy is low, with i_func, i_char_code, i_read_row
// and i_read_col sampled at that edge. Every command yields one result, shown for
// one cycle with o_done high; the receiver cannot stall, so results are never held.
// Timing from the accepting edge to the result, set by the single write port
// of the screen RAM and its registered read:
//   put character or newline without scroll: result in the next cycle, busy stays low;
//   read one cell: registered RAM read, then ST_READ; unused code: next cycle;
//   put that scrolls: ST_SCROLL writes one blank cell per column of the new row;
//   clear: ST_FILL writes the whole screen, one cell written per cycle.
// Scrolling rotates a top-row pointer rather than moving cells.
// After reset busy stays high while all ROWS*COLUMNS cells (2000 by default) of the
// screen is filled with grey-on-black spaces. Color registers are written through
// the configuration channel, which is always ready, also during that fill.
module text_console_cursor_scroll
    import tcs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [ROW_PORT_W-1:0] i_read_row,
    input  logic [COL_PORT_W-1:0] i_read_col,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COLOR_W-1:0]    i_cfg_data,
    output logic                  o_done,
    output logic [CHAR_W-1:0]     o_cell_char,
    output logic [ATTR_W-1:0]     o_cell_attribute,
    output logic [ROW_PORT_W-1:0] o_cursor_row,
    output logic [COL_PORT_W-1:0] o_cursor_col,
    output logic                  o_scrolled
);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_top, n_top;
    logic [ADDR_W-1:0]  r_fill, n_fill;
    logic [COL_W-1:0]   r_cnt, n_cnt;
    logic [COLOR_W-1:0] r_fg, n_fg;
    logic [COLOR_W-1:0] r_bg, n_bg;
    logic               r_done, n_done;
    logic               r_scrolled, n_scrolled;
    logic               r_rd_ok, n_rd_ok;
    logic [CHAR_W-1:0]  r_cell_char, n_cell_char;
    logic [ATTR_W-1:0]  r_cell_attr, n_cell_attr;

    logic [ATTR_W-1:0]  attr;
    logic               wr_en;
    logic               wr_fill;
    logic [CELL_W-1:0]  wr_data;
    logic [COL_W-1:0]   map_col;
    logic [ADDR_W-1:0]  map_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic               rd_in_range;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CELL_W-1:0]  rd_data;
    logic               wrap;

    assign attr        = {r_bg, r_fg};
    assign map_col     = (r_state == ST_SCROLL) ? r_cnt : r_col;
    assign wr_addr     = wr_fill ? r_fill : map_addr;
    assign rd_in_range = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLUMNS);
    assign wrap        = (i_char_code == NEWLINE_CODE) || (r_col == COL_W'(COLUMNS - 1));

    tcs_addr #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_wr_addr (
        .i_top  (r_top),
        .i_row  (r_row),
        .i_col  (map_col),
        .o_addr (map_addr)
    );

    tcs_addr #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_rd_addr (
        .i_top  (r_top),
        .i_row  (ROW_W'(i_read_row)),
        .i_col  (COL_W'(i_read_col)),
        .o_addr (rd_addr)
    );

    tcs_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_screen (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_top       = r_top;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_done      = 1'b0;
        n_scrolled  = 1'b0;
        n_rd_ok     = r_rd_ok;
        n_cell_char = '0;
        n_cell_attr = '0;
        wr_en       = 1'b0;
        wr_fill     = 1'b0;
        wr_data     = {attr, SPACE_CODE};
        rd_en       = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FG:  n_fg = i_cfg_data;
                CFG_BG:  n_bg = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_fill = 1'b1;
                wr_data = RESET_CELL;
                n_fill  = r_fill + 1'b1;
                if (r_fill == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (t_func'(i_func))
                        FUNC_PUT: begin
                            if (i_char_code != NEWLINE_CODE) begin
                                wr_en   = 1'b1;
                                wr_data = {attr, i_char_code};
                            end
                            if (!wrap) begin
                                n_col  = r_col + 1'b1;
                                n_done = 1'b1;
                            end else begin
                                n_col = '0;
                                if (r_row != ROW_W'(ROWS - 1)) begin
                                    n_row  = r_row + 1'b1;
                                    n_done = 1'b1;
                                end else begin
                                    n_top   = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + 1'b1;
                                    n_cnt   = '0;
                                    n_state = ST_SCROLL;
                                end
                            end
                        end
                        FUNC_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_top   = '0;
                            n_fill  = '0;
                            n_state = ST_FILL;
                        end
                        FUNC_READ: begin
                            rd_en   = rd_in_range;
                            n_rd_ok = rd_in_range;
                            n_state = ST_READ;
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                n_done  = 1'b1;
                n_state = ST_IDLE;
                if (r_rd_ok) begin
                    n_cell_char = rd_data[CHAR_W-1:0];
                    n_cell_attr = rd_data[CELL_W-1:CHAR_W];
                end
            end
            ST_SCROLL: begin
                wr_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == COL_W'(COLUMNS - 1)) begin
                    n_done     = 1'b1;
                    n_scrolled = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_FILL: begin
                wr_en   = 1'b1;
                wr_fill = 1'b1;
                n_fill  = r_fill + 1'b1;
                if (r_fill == ADDR_W'(DEPTH - 1)) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_row      <= '0;
            r_col      <= '0;
            r_top      <= '0;
            r_fill     <= '0;
            r_cnt      <= '0;
            r_fg       <= RESET_FG;
            r_bg       <= RESET_BG;
            r_done     <= 1'b0;
            r_scrolled <= 1'b0;
            r_rd_ok    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_top      <= n_top;
            r_fill     <= n_fill;
            r_cnt      <= n_cnt;
            r_fg       <= n_fg;
            r_bg       <= n_bg;
            r_done     <= n_done;
            r_scrolled <= n_scrolled;
            r_rd_ok    <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell_char <= n_cell_char;
        r_cell_attr <= n_cell_attr;
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_done           = r_done;
    assign o_cell_char      = r_cell_char;
    assign o_cell_attribute = r_cell_attr;
    assign o_cursor_row     = ROW_PORT_W'(r_row);
    assign o_cursor_col     = COL_PORT_W'(r_col);
    assign o_scrolled       = r_scrolled;
endmodule

FILE: hdl/tcs_checker.sv
// Port-level assertions for the text console engine and the bind that attaches them.
module tcs_checker
    import tcs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [FUNC_W-1:0]     i_func,
    input logic                  o_done,
    input logic [ROW_PORT_W-1:0] o_cursor_row,
    input logic [COL_PORT_W-1:0] o_cursor_col,
    input logic                  o_scrolled
);
    // The screen fill after reset keeps new commands out.
    a_reset_fill: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy not raised after reset");

    // A read transaction keeps the block busy, with no result, in the cycle after it is accepted.
    a_read_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_READ) |=> (busy && !o_done))
        else $error("read result did not wait for the memory");

    // A scroll always leaves the cursor at the start of the bottom row.
    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_scrolled |-> (o_done && 32'(o_cursor_row) == ROWS - 1 && o_cursor_col == '0))
        else $error("scroll result with cursor off the bottom row start");

    // The cursor never leaves the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_cursor_row) < ROWS && 32'(o_cursor_col) < COLUMNS))
        else $error("cursor outside the screen");
endmodule

bind text_console_cursor_scroll tcs_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_func       (i_func),
    .o_done       (o_done),
    .o_cursor_row (o_cursor_row),
    .o_cursor_col (o_cursor_col),
    .o_scrolled   (o_scrolled)
);

FILE: dv/tb_text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text console engine: directed and random commands.
module tb_text_console_cursor_scroll
    import tcs_pkg::*;
();

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    localparam int WATCHDOG_LIMIT = 10 * (ROWS * COLUMNS + 16);

    localparam logic [FUNC_W-1:0]    FUNC_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0]     cell_char;
        logic [ATTR_W-1:0]     cell_attr;
        logic [ROW_PORT_W-1:0] row;
        logic [COL_PORT_W-1:0] col;
        logic                  scrolled;
    } t_status;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [FUNC_W-1:0]     i_func = FUNC_PUT;
    logic [CHAR_W-1:0]     i_char_code = '0;
    logic [ROW_PORT_W-1:0] i_read_row = '0;
    logic [COL_PORT_W-1:0] i_read_col = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_FG;
    logic [COLOR_W-1:0]    i_cfg_data = '0;
    logic                  o_done;
    logic [CHAR_W-1:0]     o_cell_char;
    logic [ATTR_W-1:0]     o_cell_attribute;
    logic [ROW_PORT_W-1:0] o_cursor_row;
    logic [COL_PORT_W-1:0] o_cursor_col;
    logic                  o_scrolled;

    logic [CELL_W-1:0]     shadow_screen [0:ROWS*COLUMNS-1];
    logic [ROW_PORT_W-1:0] shadow_row;
    logic [COL_PORT_W-1:0] shadow_col;
    logic [COLOR_W-1:0]    shadow_fg;
    logic [COLOR_W-1:0]    shadow_bg;

    t_status pending_status [$];
    bit      gaps_enabled = 1'b1;
    int      fail_count = 0;
    int      n_commands = 0;
    int      n_puts = 0;
    int      n_reads = 0;
    int      n_clears = 0;
    int      n_scrolls = 0;
    int      n_checked = 0;
    int      stall_cycles = 0;

    text_console_cursor_scroll #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_char_code     (i_char_code),
        .i_read_row      (i_read_row),
        .i_read_col      (i_read_col),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_cell_char     (o_cell_char),
        .o_cell_attribute(o_cell_attribute),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_col    (o_cursor_col),
        .o_scrolled      (o_scrolled)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [CELL_W-1:0] blank_cell();
        return {shadow_bg, shadow_fg, SPACE_CODE};
    endfunction

    function automatic bit next_line();
        shadow_row++;
        if (int'(shadow_row) < ROWS) begin
            return 1'b0;
        end
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            shadow_screen[i] = shadow_screen[i + COLUMNS];
        end
        for (int c = 0; c < COLUMNS; c++) begin
            shadow_screen[(ROWS - 1) * COLUMNS + c] = blank_cell();
        end
        shadow_row = ROW_PORT_W'(ROWS - 1);
        return 1'b1;
    endfunction

    function automatic t_status apply_command(input logic [FUNC_W-1:0] func,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [ROW_PORT_W-1:0] rrow,
                                              input logic [COL_PORT_W-1:0] rcol);
        t_status           r;
        logic [CELL_W-1:0] mem_word;
        r = '0;
        case (func)
            FUNC_PUT: begin
                if (ch == NEWLINE_CODE) begin
                    shadow_col = '0;
                    r.scrolled = next_line();
                end else begin
                    shadow_screen[int'(shadow_row) * COLUMNS + int'(shadow_col)] =
                        {shadow_bg, shadow_fg, ch};
                    shadow_col++;
                    if (int'(shadow_col) >= COLUMNS) begin
                        shadow_col = '0;
                        r.scrolled = next_line();
                    end
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < ROWS * COLUMNS; i++) begin
                    shadow_screen[i] = blank_cell();
                end
                shadow_row = '0;
                shadow_col = '0;
            end
            FUNC_READ: begin
                if (int'(rrow) < ROWS && int'(rcol) < COLUMNS) begin
                    mem_word = shadow_screen[int'(rrow) * COLUMNS + int'(rcol)];
                    r.cell_char = mem_word[CHAR_W-1:0];
                    r.cell_attr = mem_word[CELL_W-1:CHAR_W];
                end
            end
            default: begin
            end
        endcase
        r.row = shadow_row;
        r.col = shadow_col;
        return r;
    endfunction

    task automatic send_command(input logic [FUNC_W-1:0] func,
                                input logic [CHAR_W-1:0] ch,
                                input logic [ROW_PORT_W-1:0] rrow,
                                input logic [COL_PORT_W-1:0] rcol);
        t_status st;
        if (gaps_enabled && $urandom_range(99) < 20) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_func      <= func;
        i_char_code <= ch;
        i_read_row  <= rrow;
        i_read_col  <= rcol;
        do @(posedge i_clk); while (busy);
        st = apply_command(func, ch, rrow, rcol);
        pending_status.push_back(st);
        n_commands++;
        if (func == FUNC_PUT) n_puts++;
        if (func == FUNC_READ) n_reads++;
        if (func == FUNC_CLEAR) n_clears++;
        if (st.scrolled) n_scrolls++;
    endtask

    task automatic drain_block();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_status.size() != 0);
    endtask

    // Both color registers are written, followed by the two unused indexes,
    // which must leave the colors untouched.
    task automatic program_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [COLOR_W-1:0]   val [4];
        idx = '{CFG_FG, CFG_BG, CFG_SPARE_A, CFG_SPARE_B};
        val = '{fg, bg, COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15))};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            if (idx[i] == CFG_FG) shadow_fg = val[i];
            if (idx[i] == CFG_BG) shadow_bg = val[i];
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_status want;
        if (i_rst_n && o_done) begin
            if (pending_status.size() == 0) begin
                $error("result transaction with no command outstanding");
                fail_count++;
            end else begin
                want = pending_status.pop_front();
                check_field("cell_char", int'(want.cell_char), int'(o_cell_char));
                check_field("cell_attribute", int'(want.cell_attr), int'(o_cell_attribute));
                check_field("cursor_row", int'(want.row), int'(o_cursor_row));
                check_field("cursor_col", int'(want.col), int'(o_cursor_col));
                check_field("scrolled", int'(want.scrolled), int'(o_scrolled));
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("[text_console_cursor_scroll] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic test_reset_state();
        send_command(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_command(FUNC_READ, 8'hFF, ROW_PORT_W'(ROWS - 1), COL_PORT_W'(COLUMNS - 1));
    endtask

    task automatic test_put_edges();
        send_command(FUNC_PUT, 8'h00, 5'd31, 7'd127);
        send_command(FUNC_PUT, 8'hFF, 5'd0, 7'd0);
        send_command(FUNC_PUT, 8'd13, 5'd0, 7'd0);
        send_command(FUNC_PUT, 8'd8, 5'd0, 7'd0);
        send_command(FUNC_PUT, 8'd127, 5'd0, 7'd0);
        send_command(FUNC_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        send_command(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_command(FUNC_READ, 8'h00, 5'd0, 7'd1);
        send_command(FUNC_READ, 8'h00, 5'd0, 7'd4);
    endtask

    task automatic test_out_of_range_reads();
        send_command(FUNC_READ, 8'h00, ROW_PORT_W'(ROWS), 7'd0);
        send_command(FUNC_READ, 8'h00, 5'd0, COL_PORT_W'(COLUMNS));
        send_command(FUNC_READ, 8'h00, 5'd31, 7'd127);
    endtask

    task automatic test_spare_func();
        send_command(FUNC_SPARE, NEWLINE_CODE, 5'd0, 7'd0);
    endtask

    task automatic test_colors_and_clear();
        drain_block();
        program_colors(4'd15, 4'd15);
        send_command(FUNC_PUT, 8'h41, 5'd0, 7'd0);
        send_command(FUNC_READ, 8'h00, 5'd1, 7'd0);
        drain_block();
        program_colors(4'd0, 4'd0);
        send_command(FUNC_CLEAR, 8'h00, 5'd0, 7'd0);
        send_command(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_command(FUNC_READ, 8'h00, ROW_PORT_W'(ROWS - 1), COL_PORT_W'(COLUMNS - 1));
    endtask

    task automatic test_random_phase(input logic [COLOR_W-1:0] fg,
                                     input logic [COLOR_W-1:0] bg,
                                     input int n_items, input bit with_gaps);
        int                    sel;
        int                    sub;
        logic [FUNC_W-1:0]     func;
        logic [CHAR_W-1:0]     ch;
        logic [ROW_PORT_W-1:0] rrow;
        logic [COL_PORT_W-1:0] rcol;
        drain_block();
        program_colors(fg, bg);
        gaps_enabled = with_gaps;
        for (int n = 0; n < n_items; n++) begin
            sel  = int'($urandom_range(999));
            sub  = int'($urandom_range(99));
            ch   = CHAR_W'($urandom_range(255));
            rrow = ROW_PORT_W'($urandom_range(31));
            rcol = COL_PORT_W'($urandom_range(127));
            if (sel < 600) begin
                func = FUNC_PUT;
                if (sub < 12) ch = NEWLINE_CODE;
                else if (sub < 25) ch = CHAR_W'($urandom_range(31));
            end else if (sel < 950) begin
                func = FUNC_READ;
                if (sub < 85) begin
                    rrow = ROW_PORT_W'($urandom_range(ROWS - 1));
                    rcol = COL_PORT_W'($urandom_range(COLUMNS - 1));
                    if ($urandom_range(99) < 30) begin
                        rrow = shadow_row;
                        rcol = (shadow_col == '0) ? shadow_col : shadow_col - 1'b1;
                    end
                end
            end else if (sel < 969) begin
                func = FUNC_SPARE;
            end else if (sel < 970) begin
                func = FUNC_CLEAR;
            end else begin
                func = FUNC_PUT;
                ch   = NEWLINE_CODE;
            end
            send_command(func, ch, rrow, rcol);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        program_colors(RESET_FG, RESET_BG);
        for (int i = 0; i < ROWS * COLUMNS; i++) begin
            shadow_screen[i] = RESET_CELL;
        end
        shadow_row = '0;
        shadow_col = '0;

        test_reset_state();
        test_put_edges();
        test_out_of_range_reads();
        test_spare_func();
        test_colors_and_clear();

        test_random_phase(4'd7, 4'd0, 250, 1'b1);
        test_random_phase(4'd15, 4'd15, 250, 1'b1);
        test_random_phase(4'd15, 4'd0, 250, 1'b0);
        test_random_phase(4'd0, 4'd15, 250, 1'b1);
        test_random_phase(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)), 250, 1'b1);
        test_random_phase(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)), 250, 1'b1);

        drain_block();
        repeat (20) @(posedge i_clk);
        $display("covered %0d commands: %0d puts, %0d reads, %0d clears, %0d scrolls",
                 n_commands, n_puts, n_reads, n_clears, n_scrolls);
        $display("%0d results checked, %0d mismatches", n_checked, fail_count);
        if (fail_count == 0) begin
            $display("[text_console_cursor_scroll] OK");
        end else begin
            $display("[text_console_cursor_scroll] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/tcs_pkg.sv
hdl/tcs_ram.sv
hdl/tcs_addr.sv
hdl/text_console_cursor_scroll.sv
hdl/tcs_checker.sv
dv/tb_text_console_cursor_scroll.sv
